>>> rtl/hrpd_pkg.sv
package hrpd_pkg;

  // Largest accepted image side; configured sides above it are clamped.
  localparam int MAX_SIDE = 2048;

  localparam int CFG_W   = 12;  // width of each size register
  localparam int PIX_W   = 23;  // pixel counts and run lengths
  localparam int BYTE_W  = 8;
  localparam int RGB_W   = 24;
  localparam int PAL_AW  = 8;   // 256 palette entries
  localparam int HDR_W   = 10;  // header byte counter
  localparam int KIND_W  = 2;

  localparam logic [HDR_W-1:0]  HEADER_BYTES = HDR_W'(768);
  localparam logic [HDR_W-1:0]  MARKER_LAST  = HDR_W'(768 + 3 - 1);
  localparam logic [RGB_W-1:0]  RLE_MARK     = 24'h524C45;  // "RLE"
  localparam logic [BYTE_W-1:0] ESCAPE_BYTE  = 8'hFD;

  // Input command codes
  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_PIXEL  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DONE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SHORT  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SPARSE = 2'd3;

  // Configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Run request queue between the byte decoder and the palette read
  localparam int RQ_DEPTH = 8;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);
  localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);
  localparam int RQ_PUSH  = 3;  // most requests one input transaction can make

  typedef enum logic [2:0] {
    MODE_PAL = 3'b001,
    MODE_RLE = 3'b010,
    MODE_RAW = 3'b100
  } mode_t;

  typedef enum logic [2:0] {
    ESC_NORMAL = 3'b001,
    ESC_MARK   = 3'b010,
    ESC_COUNT  = 3'b100
  } esc_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PAL_AW-1:0] idx;
    logic [PIX_W-1:0]  len;
    logic              last;
  } req_t;

  // bit 4: character is a hex digit, bits 3..0: its value
  function automatic logic [4:0] hex_val(input logic [BYTE_W-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic [CFG_W-1:0] side_clamp(input logic [CFG_W-1:0] r);
    logic [CFG_W-1:0] s;
    s = r;
    if (r == '0) begin
      s = CFG_W'(1);
    end else if (int'(r) > MAX_SIDE) begin
      s = CFG_W'(MAX_SIDE);
    end
    return s;
  endfunction

  function automatic logic [PIX_W-1:0] clamp_len(input logic [PIX_W-1:0] n,
                                                 input logic [PIX_W-1:0] left);
    return (n > left) ? left : n;
  endfunction

endpackage

>>> rtl/hrpd_palette_ram.sv
module hrpd_palette_ram (
  input  logic                         clk,
  input  logic                         we,
  input  logic [hrpd_pkg::PAL_AW-1:0]  waddr,
  input  logic [hrpd_pkg::RGB_W-1:0]   wdata,
  input  logic                         re,
  input  logic [hrpd_pkg::PAL_AW-1:0]  raddr,
  output logic [hrpd_pkg::RGB_W-1:0]   rdata
);
  import hrpd_pkg::*;

  logic [RGB_W-1:0] mem [2**PAL_AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read-first, data held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/hex_rle_palette_pixel_decoder_top.sv
// Hex thumbnail pixel decoder. Takes one body character per transaction on
// s_* (cmd on s_tuser, character on s_tdata); non-hex characters are
// dropped and digit pairs form bytes. The first 768 bytes of a frame load the
// 256-entry RGB palette, three more bytes choose escape-coded ("RLE") or raw
// index data, and each index or escape run goes out on m_* as one pixel-run
// transaction, clamped to width*height. An end command (cmd = 1) closes the frame with a
// status transaction (tlast = 1), padding with palette entry 0 once half the pixels are out.
// Rate: one input and one output transaction per cycle, unless s_tready or m_tready is low.
// Decoded runs sit in an 8-deep request queue ahead of the palette read, which
// passes a RAM read and an output register; the input stalls when fewer
// than three queue slots are free, since one transaction can make up to three
// runs (the first raw indices after the marker). While a frame loads its
// palette, input waits until the queue of the previous frame is empty, so the
// new colours never overtake runs that still have to read the old ones.
// Size registers may be written on any cycle the block is idle.
module hex_rle_palette_pixel_decoder_top (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,  // 0 image_width, 1 image_height
  input  logic [hrpd_pkg::CFG_W-1:0]    cfg_data,
  // character stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,    // char_code[7:0]
  input  logic                          s_tuser,    // cmd
  // pixel run / status stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [47:0]                   m_tdata,    // blue[7:0], green[15:8], red[23:16],
                                                    // run_length[46:24], zero pad
  output logic [hrpd_pkg::KIND_W-1:0]   m_tuser,    // kind
  output logic                          m_tlast     // closing status of a frame
);
  import hrpd_pkg::*;

  // ---------------- configuration ----------------
  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [PIX_W-1:0] total;       // clamped width * clamped height
  logic [CFG_W-1:0] side_w_next;
  logic [CFG_W-1:0] side_h_next;

  assign cfg_ready = 1'b1;

  // total is recomputed from the incoming value so it is valid the cycle after
  always_comb begin
    side_w_next = side_clamp(image_width);
    side_h_next = side_clamp(image_height);
    if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:  side_w_next = side_clamp(cfg_data);
        REG_HEIGHT: side_h_next = side_clamp(cfg_data);
        default:    side_w_next = side_clamp(image_width);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_W'(1);
      image_height <= CFG_W'(1);
      total        <= PIX_W'(1);
    end else if (cfg_valid) begin
      if (cfg_index == REG_WIDTH) begin
        image_width <= cfg_data;
      end else begin
        image_height <= cfg_data;
      end
      total <= PIX_W'(side_w_next) * PIX_W'(side_h_next);
    end
  end

  // ---------------- frame state ----------------
  logic [4:0]        nibble_pending, nibble_pending_next;  // bit 4 = held
  logic [HDR_W-1:0]  hdr_cnt, hdr_cnt_next;
  logic [PAL_AW-1:0] pal_entry, pal_entry_next;
  logic [1:0]        pal_comp, pal_comp_next;             // 0 red, 1 green, 2 blue
  logic [BYTE_W-1:0] red_hold, red_hold_next;
  logic [BYTE_W-1:0] green_hold, green_hold_next;
  mode_t             mode, mode_next;
  logic [RGB_W-1:0]  lookahead, lookahead_next;
  esc_t              esc, esc_next;
  logic [BYTE_W-1:0] esc_cnt, esc_cnt_next;
  logic [PIX_W-1:0]  emitted, emitted_next;

  // request queue
  req_t              rq_mem [RQ_DEPTH];
  logic [RQ_AW-1:0]  rq_wptr, rq_rptr;
  logic [RQ_CW-1:0]  rq_cnt;
  logic              rq_pop;

  // decoder outputs
  req_t              slot [RQ_PUSH];
  logic [1:0]        n_push;
  logic              pal_we;
  logic [RGB_W-1:0]  pal_wdata;

  logic              acc;
  logic              cmd;
  logic [BYTE_W-1:0] char_code;
  logic [4:0]        hv;
  logic [BYTE_W-1:0] byte_val;
  logic [PIX_W-1:0]  left;
  logic [PIX_W-1:0]  run_len;

  assign s_tready  = (rq_cnt <= RQ_CW'(RQ_DEPTH - RQ_PUSH)) &&
                     ((mode != MODE_PAL) || (rq_cnt == '0));
  assign acc       = s_tvalid && s_tready;
  assign cmd       = s_tuser;
  assign char_code = s_tdata;
  assign hv        = hex_val(char_code);
  assign byte_val  = {nibble_pending[3:0], hv[3:0]};
  assign left      = (total > emitted) ? (total - emitted) : '0;

  always_comb begin
    nibble_pending_next = nibble_pending;
    hdr_cnt_next        = hdr_cnt;
    pal_entry_next      = pal_entry;
    pal_comp_next       = pal_comp;
    red_hold_next       = red_hold;
    green_hold_next     = green_hold;
    mode_next           = mode;
    lookahead_next      = lookahead;
    esc_next            = esc;
    esc_cnt_next        = esc_cnt;
    emitted_next        = emitted;
    pal_we              = 1'b0;
    pal_wdata           = {red_hold, green_hold, byte_val};
    n_push              = 2'd0;
    run_len             = '0;
    for (int i = 0; i < RQ_PUSH; i++) begin
      slot[i] = '{kind: KIND_PIXEL, idx: '0, len: PIX_W'(1), last: 1'b0};
    end

    if (acc) begin
      if (cmd == CMD_CHAR) begin
        if (hv[4]) begin
          if (!nibble_pending[4]) begin
            nibble_pending_next = hv;
          end else begin
            nibble_pending_next = '0;
            case (mode)
              MODE_PAL: begin
                if (hdr_cnt < HEADER_BYTES) begin
                  case (pal_comp)
                    2'd0: begin
                      red_hold_next = byte_val;
                      pal_comp_next = 2'd1;
                    end
                    2'd1: begin
                      green_hold_next = byte_val;
                      pal_comp_next   = 2'd2;
                    end
                    default: begin
                      pal_we         = 1'b1;
                      pal_comp_next  = 2'd0;
                      pal_entry_next = pal_entry + PAL_AW'(1);
                    end
                  endcase
                end else begin
                  lookahead_next = {lookahead[15:0], byte_val};
                end
                hdr_cnt_next = hdr_cnt + HDR_W'(1);
                if (hdr_cnt == MARKER_LAST) begin
                  if (lookahead_next == RLE_MARK) begin
                    mode_next = MODE_RLE;
                  end else begin
                    // the three marker bytes become the first raw indices
                    mode_next = MODE_RAW;
                    slot[0].idx = lookahead_next[23:16];
                    slot[1].idx = lookahead_next[15:8];
                    slot[2].idx = lookahead_next[7:0];
                    if (left > PIX_W'(2)) begin
                      n_push       = 2'd3;
                      emitted_next = emitted + PIX_W'(3);
                    end else begin
                      n_push       = left[1:0];
                      emitted_next = emitted + left;
                    end
                  end
                end
              end
              MODE_RAW: begin
                slot[0].idx = byte_val;
                if (left != '0) begin
                  n_push       = 2'd1;
                  emitted_next = emitted + PIX_W'(1);
                end
              end
              MODE_RLE: begin
                case (esc)
                  ESC_NORMAL: begin
                    if (byte_val == ESCAPE_BYTE) begin
                      esc_next = ESC_MARK;
                    end else begin
                      slot[0].idx = byte_val;
                      if (left != '0) begin
                        n_push       = 2'd1;
                        emitted_next = emitted + PIX_W'(1);
                      end
                    end
                  end
                  ESC_MARK: begin
                    if (byte_val == ESCAPE_BYTE) begin
                      esc_next    = ESC_NORMAL;
                      slot[0].idx = ESCAPE_BYTE;
                      if (left != '0) begin
                        n_push       = 2'd1;
                        emitted_next = emitted + PIX_W'(1);
                      end
                    end else begin
                      esc_cnt_next = byte_val;
                      esc_next     = ESC_COUNT;
                    end
                  end
                  ESC_COUNT: begin
                    esc_next    = ESC_NORMAL;
                    run_len     = clamp_len(PIX_W'(esc_cnt), left);
                    slot[0].idx = byte_val;
                    slot[0].len = run_len;
                    if (run_len != '0) begin
                      n_push       = 2'd1;
                      emitted_next = emitted + run_len;
                    end
                  end
                  default: esc_next = ESC_NORMAL;
                endcase
              end
              default: mode_next = MODE_PAL;
            endcase
          end
        end
      end else begin
        // end of data: status, possibly after a pad run of entry 0
        if (mode == MODE_PAL) begin
          slot[0] = '{kind: KIND_SHORT, idx: '0, len: '0, last: 1'b1};
          n_push  = 2'd1;
        end else if (emitted < (total >> 1)) begin
          slot[0] = '{kind: KIND_SPARSE, idx: '0, len: '0, last: 1'b1};
          n_push  = 2'd1;
        end else if (left != '0) begin
          slot[0] = '{kind: KIND_PIXEL, idx: '0, len: left, last: 1'b0};
          slot[1] = '{kind: KIND_DONE, idx: '0, len: '0, last: 1'b1};
          n_push  = 2'd2;
        end else begin
          slot[0] = '{kind: KIND_DONE, idx: '0, len: '0, last: 1'b1};
          n_push  = 2'd1;
        end
        nibble_pending_next = '0;
        hdr_cnt_next        = '0;
        pal_entry_next      = '0;
        pal_comp_next       = 2'd0;
        mode_next           = MODE_PAL;
        lookahead_next      = '0;
        esc_next            = ESC_NORMAL;
        esc_cnt_next        = '0;
        emitted_next        = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nibble_pending <= '0;
      hdr_cnt        <= '0;
      pal_entry      <= '0;
      pal_comp       <= 2'd0;
      mode           <= MODE_PAL;
      lookahead      <= '0;
      esc            <= ESC_NORMAL;
      esc_cnt        <= '0;
      emitted        <= '0;
    end else begin
      nibble_pending <= nibble_pending_next;
      hdr_cnt        <= hdr_cnt_next;
      pal_entry      <= pal_entry_next;
      pal_comp       <= pal_comp_next;
      mode           <= mode_next;
      lookahead      <= lookahead_next;
      esc            <= esc_next;
      esc_cnt        <= esc_cnt_next;
      emitted        <= emitted_next;
    end
  end

  always_ff @(posedge clk) begin
    red_hold   <= red_hold_next;
    green_hold <= green_hold_next;
  end

  // ---------------- request queue ----------------
  always_ff @(posedge clk) begin
    for (int i = 0; i < RQ_PUSH; i++) begin
      if (2'(i) < n_push) begin
        rq_mem[rq_wptr + RQ_AW'(i)] <= slot[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wptr <= '0;
      rq_rptr <= '0;
      rq_cnt  <= '0;
    end else begin
      rq_wptr <= rq_wptr + RQ_AW'(n_push);
      rq_rptr <= rq_rptr + RQ_AW'(rq_pop);
      rq_cnt  <= rq_cnt + RQ_CW'(n_push) - RQ_CW'(rq_pop);
    end
  end

  // ---------------- palette read and output ----------------
  logic             a_valid;
  req_t             a_req;
  logic             a_adv;
  logic [RGB_W-1:0] pal_rdata;
  logic             out_valid;
  logic [KIND_W-1:0] out_kind;
  logic [RGB_W-1:0] out_rgb;
  logic [PIX_W-1:0] out_len;
  logic             out_last;

  assign a_adv  = !a_valid || !out_valid || m_tready;
  assign rq_pop = (rq_cnt != '0) && a_adv;

  hrpd_palette_ram u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_entry),
    .wdata (pal_wdata),
    .re    (rq_pop),
    .raddr (rq_mem[rq_rptr].idx),
    .rdata (pal_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_adv) begin
      a_valid <= rq_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (rq_pop) begin
      a_req <= rq_mem[rq_rptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      out_valid <= a_valid;
    end
  end

  // status transactions carry no colour
  always_ff @(posedge clk) begin
    if (a_valid && (!out_valid || m_tready)) begin
      out_kind <= a_req.kind;
      out_rgb  <= (a_req.kind == KIND_PIXEL) ? pal_rdata : '0;
      out_len  <= a_req.len;
      out_last <= a_req.last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_len, out_rgb[23:16], out_rgb[15:8], out_rgb[7:0]};
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

  // ---------------- checks ----------------
  a_rq_no_overflow: assert property (@(posedge clk) disable iff (rst)
    rq_cnt <= RQ_CW'(RQ_DEPTH))
    else $error("request queue overflow");

  a_pal_load_queue_empty: assert property (@(posedge clk) disable iff (rst)
    (acc && mode == MODE_PAL) |-> (rq_cnt == '0))
    else $error("palette load while runs still queued");

  a_no_pal_write_on_read: assert property (@(posedge clk) disable iff (rst)
    pal_we |-> !rq_pop)
    else $error("palette write collides with pending read");

  a_last_is_status: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tuser != KIND_PIXEL))
    else $error("tlast on a pixel run");

  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_PIXEL) |-> (m_tdata[46:24] != '0 && !m_tlast))
    else $error("empty pixel run emitted");

endmodule

>>> dv/hrpd_run_checker.sv
module hrpd_run_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [hrpd_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [7:0]                  s_tdata,    // char_code
  input  logic                        s_tuser,    // cmd
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [47:0]                 m_tdata,    // blue, green, red, run_length, zero pad
  input  logic [hrpd_pkg::KIND_W-1:0] m_tuser,    // kind
  input  logic                        m_tlast,
  output int                          fail_count,
  output int                          pending,
  output int                          checked
);
  timeunit 1ns;
  timeprecision 1ps;

  import hrpd_pkg::*;

  localparam int MARKER_END = int'(HEADER_BYTES) + 3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] red;
    logic [PIX_W-1:0]  len;
    logic              last;
  } pixel_result_t;

  pixel_result_t expected_runs[$];

  // predicted decoder state
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic             nib_held;
  logic [3:0]       nib;
  int               hdr_count;
  logic [RGB_W-1:0] palette [256];
  mode_t            mode;
  logic [RGB_W-1:0] lookahead;
  esc_t             esc;
  logic [7:0]       esc_count;
  int               emitted;

  int mismatches;
  int compared;

  function automatic int digit_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  // 0 reads as 1, anything past MAX_SIDE as MAX_SIDE
  function automatic int side_of(input logic [CFG_W-1:0] r);
    if (r == '0) return 1;
    if (int'(r) > MAX_SIDE) return MAX_SIDE;
    return int'(r);
  endfunction

  function automatic int pixels_left();
    int t;
    t = side_of(width_reg) * side_of(height_reg);
    return (t > emitted) ? t - emitted : 0;
  endfunction

  function automatic string show(input pixel_result_t r);
    return $sformatf("kind %0d rgb %02h%02h%02h len %0d last %0b",
                     r.kind, r.red, r.green, r.blue, r.len, r.last);
  endfunction

  task automatic start_new_frame();
    nib_held  = 1'b0;
    nib       = '0;
    hdr_count = 0;
    mode      = MODE_PAL;
    lookahead = '0;
    esc       = ESC_NORMAL;
    esc_count = '0;
    emitted   = 0;
  endtask

  task automatic emit_run(input logic [7:0] idx, input int n);
    pixel_result_t r;
    int left;
    left = pixels_left();
    if (n > left) n = left;
    if (n > 0) begin
      emitted = emitted + n;
      r.kind  = KIND_PIXEL;
      r.blue  = palette[idx][7:0];
      r.green = palette[idx][15:8];
      r.red   = palette[idx][23:16];
      r.len   = PIX_W'(n);
      r.last  = 1'b0;
      expected_runs = {expected_runs, r};
    end
  endtask

  task automatic push_status(input logic [KIND_W-1:0] kind);
    pixel_result_t r;
    r      = '0;
    r.kind = kind;
    r.last = 1'b1;
    expected_runs = {expected_runs, r};
  endtask

  task automatic decode_byte(input logic [7:0] b);
    int ent;
    if (mode == MODE_PAL) begin
      if (hdr_count < int'(HEADER_BYTES)) begin
        ent = hdr_count / 3;
        case (hdr_count % 3)
          0: palette[ent][23:16] = b;
          1: palette[ent][15:8]  = b;
          default: palette[ent][7:0] = b;
        endcase
      end else begin
        lookahead = {lookahead[15:0], b};
      end
      hdr_count++;
      if (hdr_count == MARKER_END) begin
        if (lookahead == RLE_MARK) begin
          mode = MODE_RLE;
        end else begin
          // no marker: the three bytes already are pixel indices
          mode = MODE_RAW;
          emit_run(lookahead[23:16], 1);
          emit_run(lookahead[15:8], 1);
          emit_run(lookahead[7:0], 1);
        end
      end
    end else if (mode == MODE_RAW) begin
      emit_run(b, 1);
    end else begin
      case (esc)
        ESC_NORMAL: begin
          if (b == ESCAPE_BYTE) esc = ESC_MARK;
          else emit_run(b, 1);
        end
        ESC_MARK: begin
          if (b == ESCAPE_BYTE) begin
            esc = ESC_NORMAL;
            emit_run(ESCAPE_BYTE, 1);
          end else begin
            esc_count = b;
            esc       = ESC_COUNT;
          end
        end
        default: begin
          esc = ESC_NORMAL;
          emit_run(b, int'(esc_count));
        end
      endcase
    end
  endtask

  task automatic close_frame();
    if (mode == MODE_PAL) begin
      push_status(KIND_SHORT);
    end else if (emitted < (side_of(width_reg) * side_of(height_reg)) / 2) begin
      push_status(KIND_SPARSE);
    end else begin
      emit_run(8'h00, pixels_left());
      push_status(KIND_DONE);
    end
    start_new_frame();
  endtask

  task automatic decode_char(input logic cmd, input logic [7:0] ch);
    int v;
    if (cmd == CMD_END) begin
      close_frame();
    end else begin
      v = digit_value(ch);
      if (v >= 0) begin
        if (!nib_held) begin
          nib_held = 1'b1;
          nib      = v[3:0];
        end else begin
          nib_held = 1'b0;
          decode_byte({nib, v[3:0]});
        end
      end
    end
  endtask

  task automatic check_result();
    pixel_result_t got;
    pixel_result_t want;
    got.kind  = m_tuser;
    got.blue  = m_tdata[7:0];
    got.green = m_tdata[15:8];
    got.red   = m_tdata[23:16];
    got.len   = m_tdata[46:24];
    got.last  = m_tlast;
    if (expected_runs.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result: %s", show(got));
    end else begin
      want = expected_runs.pop_front();
      compared++;
      if (got.kind !== want.kind || got.blue !== want.blue || got.green !== want.green ||
          got.red !== want.red || got.len !== want.len || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected %s, got %s", show(want), show(got));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = CFG_W'(1);
      height_reg = CFG_W'(1);
      for (int i = 0; i < 256; i++) palette[i] = '0;
      start_new_frame();
      expected_runs.delete();
      mismatches = 0;
      compared   = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WIDTH) width_reg = cfg_data;
        else height_reg = cfg_data;
      end
      if (s_tvalid && s_tready) decode_char(s_tuser, s_tdata);
      if (m_tvalid && m_tready) check_result();
    end
    fail_count <= mismatches;
    pending    <= expected_runs.size();
    checked    <= compared;
  end

endmodule

>>> dv/tb_hex_rle_palette_pixel_decoder_top.sv
module tb_hex_rle_palette_pixel_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hrpd_pkg::*;

  localparam int DRAIN_CYCLES      = 16;         // pipeline depth plus margin
  localparam int HOLD_CYCLES       = 300;        // receiver back-pressure stretch
  localparam int RANDOM_BODY_BYTES = 360;        // body bytes in the random part
  localparam int PRESSURE_FRAME    = 1;          // random frame with the long hold
  localparam int CALM_FRAME        = 3;          // random frame with no idling
  localparam int TIMEOUT_NS        = 2_000_000;

  // characters right at the edges of the hex digit ranges, plus 00 / FF
  localparam logic [63:0] EDGE_CHARS = {8'h2F, 8'h3A, 8'h40, 8'h47,
                                        8'h60, 8'h67, 8'h00, 8'hFF};

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_data  = '0;
  logic             s_tvalid  = 1'b0;
  logic [7:0]       s_tdata   = '0;
  logic             s_tuser   = 1'b0;
  logic             m_tready  = 1'b0;

  wire              cfg_ready;
  wire              s_tready;
  wire              m_tvalid;
  wire [47:0]       m_tdata;
  wire [KIND_W-1:0] m_tuser;
  wire              m_tlast;

  int fail_count;
  int pending;
  int checked;

  // stimulus controls, most of them shared with the receiver process
  bit calm      = 1'b0;
  int noise_pct = 4;
  int hold_go   = 0;
  int hold_seen = 0;

  int frames     = 0;
  int body_items = 0;
  int frame_no;

  hex_rle_palette_pixel_decoder_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  hrpd_run_checker run_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop in case the decoder hangs or drops a result.
  initial begin
    #TIMEOUT_NS;
    $display("timeout with %0d results still expected", pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver: random ready, always ready in the calm frame, and one long
  // hold-off counted here so the sender keeps pushing into a full pipe.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_go != hold_seen) begin
        hold_seen = hold_go;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_tready <= calm || ($urandom_range(99) >= 27);
      end
    end
  end

  function automatic bit is_hex_digit(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < 4'd10) return 8'h30 + {4'd0, v};
    return (upper ? 8'h41 : 8'h61) + {4'd0, v} - 8'd10;
  endfunction

  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    c = 8'($urandom);
    while (is_hex_digit(c)) c = 8'($urandom);
    return c;
  endfunction

  function automatic logic [CFG_W-1:0] extreme_side();
    case ($urandom_range(4))
      0: return CFG_W'(0);
      1: return CFG_W'(1);
      2: return CFG_W'(MAX_SIDE);
      3: return CFG_W'(MAX_SIDE - 1);
      default: return '1;
    endcase
  endfunction

  // One character transaction. Random idle cycles go in front; valid is
  // only ever assigned once per edge so back-to-back items stay high.
  task automatic send_item(input logic cmd, input logic [7:0] ch);
    while (!calm && $urandom_range(99) < 27) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= ch;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Byte as two hex digits, high nibble first, random letter case and
  // the odd non-hex character mixed in.
  task automatic send_byte(input logic [7:0] b);
    for (int half = 1; half >= 0; half--) begin
      if ($urandom_range(99) < noise_pct) send_item(CMD_CHAR, noise_char());
      send_item(CMD_CHAR, hex_char(b[4*half +: 4], 1'($urandom_range(1))));
    end
  endtask

  task automatic send_palette(input bit extremes);
    logic [RGB_W-1:0] rgb;
    for (int e = 0; e < 256; e++) begin
      rgb = RGB_W'($urandom);
      if (extremes && e == 0) rgb = '0;
      else if (extremes && e == 255) rgb = '1;
      send_byte(rgb[23:16]);
      send_byte(rgb[15:8]);
      send_byte(rgb[7:0]);
    end
  endtask

  task automatic send_marker(input logic [23:0] m);
    send_byte(m[23:16]);
    send_byte(m[15:8]);
    send_byte(m[7:0]);
  endtask

  task automatic end_frame();
    send_item(CMD_END, 8'($urandom));
    frames++;
  endtask

  // Quiesce: stop offering, wait for every predicted result, then give the
  // pipe time to flush work that produces no output (full frame, n = 0).
  task automatic settle();
    s_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  // Random frame: mostly well-formed (palette, marker, body) with random
  // content; some cut short anywhere before the last marker byte.
  task automatic random_frame(input int idx);
    int pick;
    int cut;
    int target;
    int sent;
    int n;
    bit rle;
    logic [7:0]  b;
    logic [23:0] marker;

    pick = $urandom_range(99);
    if (idx == PRESSURE_FRAME) begin
      set_size(CFG_W'(48), CFG_W'(40));
    end else if (pick < 75) begin
      set_size(CFG_W'($urandom_range(1, 12)), CFG_W'($urandom_range(1, 8)));
    end else if (pick < 87) begin
      set_size(extreme_side(), extreme_side());
    end else begin
      // wide, few rows: long runs needed to get past the half-full mark
      set_size(CFG_W'($urandom), CFG_W'($urandom_range(0, 2)));
    end

    if (idx != PRESSURE_FRAME && $urandom_range(99) < 15) begin
      // broken frame: ends inside the palette or the marker
      cut = ($urandom_range(3) == 0) ? $urandom_range(766, 770) : $urandom_range(0, 770);
      for (int i = 0; i < cut; i++) begin
        send_byte(i < 768 ? 8'($urandom) : RLE_MARK[8*(770-i) +: 8]);
      end
      if ($urandom_range(1)) send_item(CMD_CHAR, hex_char(4'($urandom), 1'b0));
      end_frame();
      return;
    end

    send_palette(1'b0);
    rle = (idx == PRESSURE_FRAME) || ($urandom_range(99) < 70);
    if (rle) marker = RLE_MARK;
    else if ($urandom_range(1)) marker = 24'($urandom);
    else marker = RLE_MARK ^ (24'h1 << $urandom_range(23));  // near miss
    send_marker(marker);

    // receiver stalls from here while the body keeps coming
    if (idx == PRESSURE_FRAME) hold_go++;

    target = $urandom_range(30, 80);
    sent   = 0;
    while (sent < target) begin
      pick = $urandom_range(99);
      if (!rle || pick < 50) begin
        b = 8'($urandom);
        if (rle && b == ESCAPE_BYTE) b = 8'hFE;
        send_byte(b);
        sent += 1;
      end else if (pick < 65) begin
        send_byte(ESCAPE_BYTE);
        send_byte(ESCAPE_BYTE);
        sent += 2;
      end else begin
        pick = $urandom_range(9);
        if (pick == 0) n = 0;
        else if (pick == 1) n = 255;
        else if (pick < 4) n = $urandom_range(255);
        else n = $urandom_range(1, 8);
        if (n == int'(ESCAPE_BYTE)) n = 1;
        send_byte(ESCAPE_BYTE);
        send_byte(8'(n));
        send_byte(8'($urandom));
        sent += 3;
      end
    end
    body_items += sent;

    // loose ends that the end command must drop
    pick = $urandom_range(9);
    if (pick == 0) begin
      send_item(CMD_CHAR, hex_char(4'($urandom), 1'b1));
    end else if (pick == 1 && rle) begin
      send_byte(ESCAPE_BYTE);
    end else if (pick == 2 && rle) begin
      send_byte(ESCAPE_BYTE);
      send_byte(8'($urandom_range(1, 200)));
    end
    end_frame();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed part ---

    // end on an empty frame: short status, both sides at 0 (taken as 1)
    set_size(CFG_W'(0), CFG_W'(0));
    end_frame();
    settle();

    // escape-coded frame of 8 pixels: literals, escaped FD, a run, a
    // zero-length run, a run clamped at the frame end, then frame full
    // and a dangling nibble before the end
    set_size(CFG_W'(4), CFG_W'(2));
    send_palette(1'b1);
    send_marker(RLE_MARK);
    for (int i = 0; i < 8; i++) send_item(CMD_CHAR, EDGE_CHARS[8*i +: 8]);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ESCAPE_BYTE);
    send_byte(ESCAPE_BYTE);
    send_marker({ESCAPE_BYTE, 8'h03, 8'h07});
    send_marker({ESCAPE_BYTE, 8'h00, 8'h05});
    send_marker({ESCAPE_BYTE, 8'h0A, 8'h01});
    send_byte(8'h20);
    send_item(CMD_CHAR, 8'h33);
    end_frame();
    settle();

    // raw frame with a near-miss marker: three indices at once, one more
    // raw index, then the end pads the rest with entry 0
    set_size(CFG_W'(0), CFG_W'(5));
    send_palette(1'b0);
    send_marker(24'h524C46);
    send_byte(8'hAB);
    end_frame();
    settle();

    // largest frame, one long run, unfinished escape: too few pixels
    set_size(CFG_W'(4095), CFG_W'(MAX_SIDE));
    send_palette(1'b0);
    send_marker(RLE_MARK);
    send_marker({ESCAPE_BYTE, 8'hFF, 8'h11});
    send_byte(ESCAPE_BYTE);
    send_byte(8'h05);
    end_frame();
    settle();

    // size shrinks mid-frame below what was already sent
    set_size(CFG_W'(8), CFG_W'(8));
    send_palette(1'b0);
    send_marker(RLE_MARK);
    send_marker({ESCAPE_BYTE, 8'h28, 8'h02});
    settle();
    set_size(CFG_W'(2), CFG_W'(2));
    send_byte(8'h05);
    end_frame();
    settle();

    // end inside the palette
    set_size(CFG_W'(MAX_SIDE), CFG_W'(1));
    for (int i = 0; i < 10; i++) send_byte(8'($urandom));
    end_frame();

    // --- random part ---
    frame_no = 0;
    while (body_items < RANDOM_BODY_BYTES || frame_no <= CALM_FRAME + 1) begin
      settle();
      calm = (frame_no == CALM_FRAME);
      random_frame(frame_no);
      frame_no++;
    end
    calm = 1'b0;
    settle();

    $display("covered %0d frames (%0d random), %0d random body bytes, %0d results checked",
             frames, frame_no, body_items, checked);
    $display("sides from 0 to 4095, escape and raw bodies, short, sparse and full ends");
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d failures, %0d results never arrived", fail_count, pending);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
